// ===== rtl/accel_peak_detector_unit_defines.svh =====
// Assertion macros shared by the checker.
`ifndef ACCEL_PEAK_DETECTOR_UNIT_DEFINES_SVH
`define ACCEL_PEAK_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define APD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define APD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Same-cycle implication that also holds across reset.
`define APD_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/apd_pkg.sv =====
`timescale 1ns / 1ps

package apd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int MAG_W    = 32;
    localparam int THR_W    = 32;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    localparam logic REG_THR0 = 1'b0;
    localparam logic REG_THR1 = 1'b1;

    localparam logic [1:0] PH_START = 2'd0;
    localparam logic [1:0] PH_PEAK  = 2'd1;
    localparam logic [1:0] PH_HOLD  = 2'd2;
    localparam logic [1:0] PH_REARM = 2'd3;

    typedef struct packed {
        logic                       mode;
        logic [TIME_W-1:0]          ts;
        logic [MAG_W-1:0]           mag;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
    } apd_item_t;

    typedef struct packed {
        logic                       emit;
        logic signed [SAMPLE_W-1:0] x;
        logic signed [SAMPLE_W-1:0] y;
        logic signed [SAMPLE_W-1:0] z;
        logic [TIME_W-1:0]          period;
    } apd_result_t;

endpackage

// ===== rtl/apd_cfg_regs.sv =====
`timescale 1ns / 1ps

module apd_cfg_regs import apd_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic [THR_W-1:0]  thr0,
    output logic [THR_W-1:0]  thr1
);

    logic [THR_W-1:0] thr0_reg, thr0_next;
    logic [THR_W-1:0] thr1_reg, thr1_next;
    logic             wr_en;
    logic             reg_sel;

    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[2];

    always_comb begin
        thr0_next = thr0_reg;
        thr1_next = thr1_reg;
        if (wr_en) begin
            case (reg_sel)
                REG_THR0: thr0_next = pwdata;
                REG_THR1: thr1_next = pwdata;
                default:  thr0_next = thr0_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr0_reg <= '0;
            thr1_reg <= '0;
        end else begin
            thr0_reg <= thr0_next;
            thr1_reg <= thr1_next;
        end
    end

    always_comb begin
        case (reg_sel)
            REG_THR0: prdata = thr0_reg;
            REG_THR1: prdata = thr1_reg;
            default:  prdata = '0;
        endcase
    end

    assign thr0 = thr0_reg;
    assign thr1 = thr1_reg;

endmodule

// ===== rtl/apd_lane.sv =====
`timescale 1ns / 1ps

module apd_lane import apd_pkg::*; #(
    parameter int HOLDOFF_SAMPLES = 20
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             hit,
    input  apd_item_t        item,
    input  logic [THR_W-1:0] threshold,
    output apd_result_t      result
);

    localparam int HOLD_W = $clog2(HOLDOFF_SAMPLES + 2);

    logic [1:0]                 phase_reg, phase_next;
    logic [HOLD_W-1:0]          count_reg, count_next;
    logic                       have_prev_reg, have_prev_next;
    logic [MAG_W-1:0]           peak_mag_reg, peak_mag_next;
    logic signed [SAMPLE_W-1:0] peak_x_reg, peak_x_next;
    logic signed [SAMPLE_W-1:0] peak_y_reg, peak_y_next;
    logic signed [SAMPLE_W-1:0] peak_z_reg, peak_z_next;
    logic [TIME_W-1:0]          prev_time_reg, prev_time_next;
    logic [HOLD_W-1:0]          count_inc;
    logic                       take;

    assign count_inc = count_reg + HOLD_W'(1);

    always_comb begin
        phase_next     = phase_reg;
        count_next     = count_reg;
        have_prev_next = have_prev_reg;
        prev_time_next = prev_time_reg;
        take           = 1'b0;
        result.emit    = 1'b0;
        result.x       = peak_x_reg;
        result.y       = peak_y_reg;
        result.z       = peak_z_reg;
        result.period  = have_prev_reg ? (item.ts - prev_time_reg) : '0;

        if (item.mode == MODE_RESTART) begin
            phase_next = PH_START;
            count_next = '0;
        end else begin
            case (phase_reg)
                PH_START, PH_REARM: begin
                    if (phase_reg == PH_START) begin
                        have_prev_next = 1'b0;
                    end
                    if (item.mag >= threshold) begin
                        phase_next = PH_PEAK;
                        take       = 1'b1;
                    end
                end
                PH_PEAK: begin
                    if (item.mag >= peak_mag_reg) begin
                        take = 1'b1;
                    end else begin
                        phase_next     = PH_HOLD;
                        count_next     = HOLD_W'(1);
                        result.emit    = 1'b1;
                        have_prev_next = 1'b1;
                        prev_time_next = item.ts;
                    end
                end
                default: begin
                    count_next = count_inc;
                    if (count_inc > HOLD_W'(HOLDOFF_SAMPLES)) begin
                        count_next = '0;
                        phase_next = PH_REARM;
                    end
                end
            endcase
        end

        peak_mag_next = take ? item.mag : peak_mag_reg;
        peak_x_next   = take ? item.x   : peak_x_reg;
        peak_y_next   = take ? item.y   : peak_y_reg;
        peak_z_next   = take ? item.z   : peak_z_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_START;
            count_reg     <= '0;
            have_prev_reg <= 1'b0;
        end else if (hit) begin
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            have_prev_reg <= have_prev_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (hit) begin
            peak_mag_reg  <= peak_mag_next;
            peak_x_reg    <= peak_x_next;
            peak_y_reg    <= peak_y_next;
            peak_z_reg    <= peak_z_next;
            prev_time_reg <= prev_time_next;
        end
    end

endmodule

// ===== rtl/accel_peak_detector_unit.sv =====
`timescale 1ns / 1ps

// Accelerometer peak detector with holdoff, one independent detector per
// controller. Each item is squared per axis as it enters the input register
// and summed, compared and applied to the detector state as it leaves that
// register, which loads the result register. Throughput is one item per
// clock unless stalled; a peak shows on m_valid from the result register.
// The pipeline stalls only while the result register holds a peak that
// m_ready has not yet taken. Thresholds sit at byte addresses 0 (controller
// 0) and 4 (controller 1); write them while no transaction is in flight.
module accel_peak_detector_unit import apd_pkg::*; #(
    parameter int HOLDOFF_SAMPLES = 20,
    parameter int SAMPLE_BITS     = 16,
    parameter int CONTROLLERS     = 2
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_mode,
    input  logic                       s_controller,
    input  logic signed [SAMPLE_W-1:0] s_accel_x,
    input  logic signed [SAMPLE_W-1:0] s_accel_y,
    input  logic signed [SAMPLE_W-1:0] s_accel_z,
    input  logic [TIME_W-1:0]          s_timestamp,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic                       m_out_controller,
    output logic signed [SAMPLE_W-1:0] m_peak_x,
    output logic signed [SAMPLE_W-1:0] m_peak_y,
    output logic signed [SAMPLE_W-1:0] m_peak_z,
    output logic [TIME_W-1:0]          m_peak_period
);

    localparam int NUM_LANES = (CONTROLLERS < 2) ? CONTROLLERS : 2;
    localparam int PROD_W    = 2 * SAMPLE_BITS;
    localparam int SQ_W      = 2 * SAMPLE_BITS - 1;

    logic [THR_W-1:0] thr0, thr1;

    apd_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .thr0    (thr0),
        .thr1    (thr1)
    );

    assign pready = 1'b1;

    // input stage
    logic signed [SAMPLE_BITS-1:0] xs, ys, zs;
    logic signed [PROD_W-1:0]      px, py, pz;
    logic                          s_fire, adv;

    logic                       s1_valid_reg, s1_valid_next;
    logic                       s1_mode_reg;
    logic                       s1_ctrl_reg;
    logic signed [SAMPLE_W-1:0] s1_x_reg, s1_y_reg, s1_z_reg;
    logic [SQ_W-1:0]            s1_sqx_reg, s1_sqy_reg, s1_sqz_reg;
    logic [TIME_W-1:0]          s1_ts_reg;

    always_comb begin
        xs = s_accel_x[SAMPLE_BITS-1:0];
        ys = s_accel_y[SAMPLE_BITS-1:0];
        zs = s_accel_z[SAMPLE_BITS-1:0];
        px = PROD_W'(xs) * PROD_W'(xs);
        py = PROD_W'(ys) * PROD_W'(ys);
        pz = PROD_W'(zs) * PROD_W'(zs);
    end

    assign adv     = s1_valid_reg && (!m_valid || m_ready);
    assign s_ready = !s1_valid_reg || adv;
    assign s_fire  = s_valid && s_ready;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s_fire) begin
            s1_valid_next = 1'b1;
        end else if (adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            s1_mode_reg <= s_mode;
            s1_ctrl_reg <= s_controller;
            s1_x_reg    <= SAMPLE_W'(xs);
            s1_y_reg    <= SAMPLE_W'(ys);
            s1_z_reg    <= SAMPLE_W'(zs);
            s1_sqx_reg  <= px[SQ_W-1:0];
            s1_sqy_reg  <= py[SQ_W-1:0];
            s1_sqz_reg  <= pz[SQ_W-1:0];
            s1_ts_reg   <= s_timestamp;
        end
    end

    // detect stage
    apd_item_t   item;
    apd_result_t lane_res [NUM_LANES];
    logic        lane_hit [NUM_LANES];
    apd_result_t sel_res;
    logic        emit;

    always_comb begin
        item.mode = s1_mode_reg;
        item.ts   = s1_ts_reg;
        item.mag  = MAG_W'(s1_sqx_reg) + MAG_W'(s1_sqy_reg) + MAG_W'(s1_sqz_reg);
        item.x    = s1_x_reg;
        item.y    = s1_y_reg;
        item.z    = s1_z_reg;
    end

    for (genvar d = 0; d < NUM_LANES; d++) begin : g_lane
        assign lane_hit[d] = adv && (s1_ctrl_reg == 1'(d));

        apd_lane #(
            .HOLDOFF_SAMPLES (HOLDOFF_SAMPLES)
        ) u_lane (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .hit       (lane_hit[d]),
            .item      (item),
            .threshold ((d == 0) ? thr0 : thr1),
            .result    (lane_res[d])
        );
    end

    always_comb begin
        sel_res = lane_res[0];
        emit    = 1'b0;
        for (int d = 0; d < NUM_LANES; d++) begin
            if (lane_hit[d] && lane_res[d].emit) begin
                sel_res = lane_res[d];
                emit    = 1'b1;
            end
        end
    end

    // result register
    logic                       m_valid_reg, m_valid_next;
    logic                       m_ctrl_reg;
    logic signed [SAMPLE_W-1:0] m_x_reg, m_y_reg, m_z_reg;
    logic [TIME_W-1:0]          m_period_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_ctrl_reg   <= s1_ctrl_reg;
            m_x_reg      <= sel_res.x;
            m_y_reg      <= sel_res.y;
            m_z_reg      <= sel_res.z;
            m_period_reg <= sel_res.period;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_controller = m_ctrl_reg;
    assign m_peak_x         = m_x_reg;
    assign m_peak_y         = m_y_reg;
    assign m_peak_z         = m_z_reg;
    assign m_peak_period    = m_period_reg;

endmodule

// ===== rtl/apd_checker.sv =====
`timescale 1ns / 1ps
`include "accel_peak_detector_unit_defines.svh"

module apd_checker import apd_pkg::*; (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_valid,
    input logic                       s_ready,
    input logic                       m_valid,
    input logic                       m_ready,
    input logic                       m_out_controller,
    input logic signed [SAMPLE_W-1:0] m_peak_x,
    input logic signed [SAMPLE_W-1:0] m_peak_y,
    input logic signed [SAMPLE_W-1:0] m_peak_z,
    input logic [TIME_W-1:0]          m_peak_period
);

    // no result and an open input right after reset
    `APD_ASSERT_ALWAYS(a_reset_idle, aclk, $past(!aresetn), !m_valid && s_ready, "not idle after reset")

    // input only backs up behind a stalled result
    `APD_ASSERT_NOW(a_backpressure, aclk, aresetn, !s_ready, m_valid && !m_ready, "s_ready low without output stall")

    // a stalled transaction keeps its payload
    `APD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_out_controller) && $stable(m_peak_x) && $stable(m_peak_y) && $stable(m_peak_z) && $stable(m_peak_period), "result changed while stalled")

endmodule

bind accel_peak_detector_unit apd_checker u_apd_checker (.*);
